>>> design/ahfb_pkg.sv
// ----------------------------------------------------------------------------
// ahfb_pkg: shared types and constants for the ASCII-hex frame builder
// Item structs, queue command format, sequencer step codes and hex helper.
// ----------------------------------------------------------------------------
package ahfb_pkg;

  // Frame constants
  localparam int unsigned AddressChars = 10;
  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] EndByte = 8'h03;
  localparam logic [7:0] ControlTopBit = 8'h80;
  localparam logic [7:0] MaxMessageLength = 8'd237;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiUpperA = 8'h41;

  // Configuration port
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 64;
  localparam logic [0:0] RegAddrFirstEight = 1'b0;
  localparam logic [0:0] RegAddrLastTwo = 1'b1;

  // Sequencer steps of the back end
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepFirst = 5'd0;
  localparam logic [StepW-1:0] StepAddrFirst = 5'd1;
  localparam logic [StepW-1:0] StepAddrLast = 5'd10;
  localparam logic [StepW-1:0] StepCodeHi = 5'd11;
  localparam logic [StepW-1:0] StepCodeLo = 5'd12;
  localparam logic [StepW-1:0] StepLenHi = 5'd13;
  localparam logic [StepW-1:0] StepLenLo = 5'd14;
  localparam logic [StepW-1:0] StepChkHi = 5'd15;
  localparam logic [StepW-1:0] StepChkLo = 5'd16;
  localparam logic [StepW-1:0] StepEnd = 5'd17;

  typedef enum logic [0:0] {
    OpStart = 1'b0,
    OpByte  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CmdStart = 1'b0,
    CmdByte  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] type_char_high;
    logic [7:0] type_char_low;
    logic [7:0] message_length;
    logic [7:0] message_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  // Command passed from the front end to the back end
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;   // control code for a start, message byte otherwise
    logic [7:0] len;    // clamped length, start only
    logic       close;  // append block check and end byte
  } cmd_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

>>> design/ahfb_front.sv
// ----------------------------------------------------------------------------
// ahfb_front: input classifier
// Accepts items, builds the control code, clamps the length, tracks the open
// frame and pushes one command per useful item into the queue.
// ----------------------------------------------------------------------------
module ahfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ahfb_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ahfb_pkg::cmd_t    q_cmd_o
);

  logic       frame_open_q, frame_open_d;
  logic [7:0] remain_q, remain_d;
  logic       accept;
  logic [7:0] len_clamped;
  logic [7:0] code_low;
  logic [7:0] code;
  logic [7:0] remain_dec;
  logic       byte_close;

  // Take an item whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  // Decode the control code and clamp the length
  always_comb begin
    len_clamped = (in_item_i.message_length > ahfb_pkg::MaxMessageLength) ?
                  ahfb_pkg::MaxMessageLength : in_item_i.message_length;
    if (in_item_i.type_char_low > ahfb_pkg::AsciiNine) begin
      code_low = in_item_i.type_char_low - ahfb_pkg::AsciiUpperA + 8'd10;
    end else begin
      code_low = {4'h0, in_item_i.type_char_low[3:0]};
    end
    code = {in_item_i.type_char_high[3:0], 4'h0} | code_low | ahfb_pkg::ControlTopBit;
  end

  // Count down message bytes
  assign remain_dec = (remain_q == 8'd0) ? 8'd0 : remain_q - 8'd1;
  assign byte_close = (remain_dec == 8'd0);

  // Build the command and the next frame state
  always_comb begin
    frame_open_d  = frame_open_q;
    remain_d      = remain_q;
    q_push_o      = 1'b0;
    q_cmd_o.kind  = ahfb_pkg::CmdStart;
    q_cmd_o.data  = code;
    q_cmd_o.len   = len_clamped;
    q_cmd_o.close = (len_clamped == 8'd0);
    if (accept) begin
      case (in_item_i.op)
        ahfb_pkg::OpStart: begin
          q_push_o     = 1'b1;
          frame_open_d = (len_clamped != 8'd0);
          remain_d     = len_clamped;
        end
        default: begin
          q_cmd_o.kind  = ahfb_pkg::CmdByte;
          q_cmd_o.data  = in_item_i.message_byte;
          q_cmd_o.close = byte_close;
          // drop a message byte when no frame is open
          if (frame_open_q) begin
            q_push_o     = 1'b1;
            remain_d     = remain_dec;
            frame_open_d = !byte_close;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remain_q     <= 8'd0;
    end else begin
      frame_open_q <= frame_open_d;
      remain_q     <= remain_d;
    end
  end

endmodule

>>> design/ahfb_cmd_queue.sv
// ----------------------------------------------------------------------------
// ahfb_cmd_queue: command queue between front and back end
// Small FIFO of commands so either side can stall on its own.
// ----------------------------------------------------------------------------
module ahfb_cmd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ahfb_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ahfb_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ahfb_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/ahfb_back.sv
// ----------------------------------------------------------------------------
// ahfb_back: frame byte sequencer
// Walks each command through its byte steps, keeps the running XOR and drives
// the registered output channel, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module ahfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         addr_first_eight_i,
  input  logic [15:0]         addr_last_two_i,
  input  logic                q_valid_i,
  input  ahfb_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ahfb_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrIdxW = $clog2(ahfb_pkg::AddressChars);

  logic [ahfb_pkg::StepW-1:0] step_q, step_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 check_q;
  logic                       out_valid_q, out_valid_d;
  ahfb_pkg::out_item_t        out_item_q;
  logic [7:0]                 addr_chars [ahfb_pkg::AddressChars];
  logic [AddrIdxW-1:0]        addr_idx;
  logic                       advance;
  logic                       is_start;
  logic                       last_step;
  logic [7:0]                 byte_c;
  logic                       end_c;

  // Unpack the address characters, first character first
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      addr_chars[k] = addr_first_eight_i[63 - 8*k -: 8];
    end
    addr_chars[8] = addr_last_two_i[15:8];
    addr_chars[9] = addr_last_two_i[7:0];
  end

  assign addr_idx = AddrIdxW'(step_q - ahfb_pkg::StepAddrFirst);
  assign is_start = (q_cmd_i.kind == ahfb_pkg::CmdStart);
  assign advance  = q_valid_i && (!out_valid_q || out_ready_i);

  // Select the byte for the current step
  always_comb begin
    byte_c = 8'h00;
    end_c  = 1'b0;
    unique case (step_q) inside
      ahfb_pkg::StepFirst: byte_c = is_start ? ahfb_pkg::StartByte : q_cmd_i.data;
      [ahfb_pkg::StepAddrFirst:ahfb_pkg::StepAddrLast]: byte_c = addr_chars[addr_idx];
      ahfb_pkg::StepCodeHi: byte_c = ahfb_pkg::hex_char(q_cmd_i.data[7:4]);
      ahfb_pkg::StepCodeLo: byte_c = ahfb_pkg::hex_char(q_cmd_i.data[3:0]);
      ahfb_pkg::StepLenHi:  byte_c = ahfb_pkg::hex_char(q_cmd_i.len[7:4]);
      ahfb_pkg::StepLenLo:  byte_c = ahfb_pkg::hex_char(q_cmd_i.len[3:0]);
      ahfb_pkg::StepChkHi:  byte_c = ahfb_pkg::hex_char(xor_q[7:4]);
      ahfb_pkg::StepChkLo:  byte_c = ahfb_pkg::hex_char(check_q[3:0]);
      ahfb_pkg::StepEnd: begin
        byte_c = ahfb_pkg::EndByte;
        end_c  = 1'b1;
      end
      default: begin
        byte_c = 8'h00;
        end_c  = 1'b0;
      end
    endcase
  end

  // Decide whether this step finishes the command
  always_comb begin
    last_step = 1'b0;
    if (step_q == ahfb_pkg::StepEnd) begin
      last_step = 1'b1;
    end else if (step_q == ahfb_pkg::StepFirst && !is_start && !q_cmd_i.close) begin
      last_step = 1'b1;
    end else if (step_q == ahfb_pkg::StepLenLo && !q_cmd_i.close) begin
      last_step = 1'b1;
    end
  end

  assign q_pop_o = advance && last_step;

  // Next step, running XOR and output register
  always_comb begin
    step_d      = step_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (last_step) begin
        step_d = ahfb_pkg::StepFirst;
      end else if (step_q == ahfb_pkg::StepFirst && !is_start) begin
        step_d = ahfb_pkg::StepChkHi;
      end else begin
        step_d = step_q + ahfb_pkg::StepW'(1);
      end
      if (step_q == ahfb_pkg::StepFirst && is_start) begin
        xor_d = ahfb_pkg::StartByte;
      end else if (step_q == ahfb_pkg::StepEnd) begin
        xor_d = 8'h00;
      end else begin
        xor_d = xor_q ^ byte_c;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ahfb_pkg::StepFirst;
      xor_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the block check and the output byte
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.frame_byte <= byte_c;
      out_item_q.frame_end  <= end_c;
      if (step_q == ahfb_pkg::StepChkHi) begin
        check_q <= xor_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> design/ascii_hex_frame_builder_xor_bcc_unit.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_builder_xor_bcc_unit: STX/ETX ASCII-hex frame builder
// Builds reply frames with address, control code, length, message bytes
// and an XOR block check, one frame byte per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------
//  in       | input     | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//  out      | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//  cfg      | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A start item yields 15 frame bytes (18 for an empty message); a message
// byte yields 1 byte, or 4 when it closes the frame. The back-end sequencer
// emits one byte per cycle into the output register, which sets the rate,
// while a command is queued and the output is not stalled. Input items are
// taken every cycle while the command queue has room; an item's first byte
// passes through the command queue and then the output register. Reset is
// asynchronous and clears all control state at once; no clearing pass needed.
// ----------------------------------------------------------------------------
module ascii_hex_frame_builder_xor_bcc_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ahfb_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ahfb_pkg::out_item_t               out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ahfb_pkg::CfgAddrW-1:0]     paddr,
  input  logic [ahfb_pkg::CfgDataW-1:0]     pwdata,
  output logic [ahfb_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready
);

  logic [63:0]    addr_first_eight_q;
  logic [15:0]    addr_last_two_q;
  logic           cfg_write;
  logic           q_full, q_push, q_pop, q_valid;
  ahfb_pkg::cmd_t push_cmd, head_cmd;

  // Register port: 8-byte stride, index in address bit 3
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_first_eight_q <= 64'd0;
      addr_last_two_q    <= 16'd0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        ahfb_pkg::RegAddrFirstEight: addr_first_eight_q <= pwdata;
        ahfb_pkg::RegAddrLastTwo:    addr_last_two_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (paddr[3])
      ahfb_pkg::RegAddrFirstEight: prdata = addr_first_eight_q;
      ahfb_pkg::RegAddrLastTwo:    prdata = {48'd0, addr_last_two_q};
      default:                     prdata = '0;
    endcase
  end

  ahfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  ahfb_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  ahfb_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .addr_first_eight_i (addr_first_eight_q),
    .addr_last_two_i    (addr_last_two_q),
    .q_valid_i          (q_valid),
    .q_cmd_i            (head_cmd),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_item_o         (out_item_o)
  );

endmodule

>>> design/ahfb_checker.sv
// ----------------------------------------------------------------------------
// ahfb_checker: port-level checks for the frame builder
// Watches the output channel and register port over time.
// ----------------------------------------------------------------------------
module ahfb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ahfb_pkg::out_item_t out_item_o,
  input logic                pready
);

  // Hold a stalled output item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // Mark the frame end only on the end byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.frame_byte == ahfb_pkg::EndByte)
    else $error("frame end flag on a byte other than the end byte");

  // Come out of reset with nothing to send
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // Keep the register port always ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind ascii_hex_frame_builder_xor_bcc_unit ahfb_checker u_ahfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .pready      (pready)
);

>>> tb/ascii_hex_frame_builder_xor_bcc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_builder_xor_bcc_unit_tb: self-checking bench for the frame builder
// Streams start and message-byte items into the block. Each accepted item is
// expanded into the frame bytes it should produce. Every output byte is then
// compared against the oldest pending byte. The address registers are
// reprogrammed over APB between phases, while the block is drained.
// ----------------------------------------------------------------------------
module ascii_hex_frame_builder_xor_bcc_unit_tb;

  localparam int unsigned IdlePct = 6;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 50;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  ahfb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ahfb_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ahfb_pkg::CfgAddrW-1:0] paddr = '0;
  logic [ahfb_pkg::CfgDataW-1:0] pwdata = '0;
  logic [ahfb_pkg::CfgDataW-1:0] prdata;
  logic pready;

  // Bench copy of the address registers and the frame state
  logic [63:0] addr_first8 = '0;
  logic [15:0] addr_last2 = '0;
  logic [7:0] bcc_acc = '0;
  logic [7:0] left_cnt = '0;
  logic frame_is_open = 1'b0;

  ahfb_pkg::in_item_t items_to_send[$];
  ahfb_pkg::out_item_t frame_bytes_due[$];
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cnt = 0;
  logic quiet = 1'b0;

  ascii_hex_frame_builder_xor_bcc_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    // Cap the printout so a broken build cannot flood the log
    if (mismatch_cnt < MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h41 + {4'h0, n} - 8'd10;
  endfunction

  // Append one frame byte and fold it into the block check
  task automatic push_byte(input logic [7:0] b, input logic is_end);
    ahfb_pkg::out_item_t ob;
    ob.frame_byte = b;
    ob.frame_end = is_end;
    frame_bytes_due.push_back(ob);
    bcc_acc = bcc_acc ^ b;
  endtask

  task automatic push_hex(input logic [7:0] v);
    push_byte(nibble_ascii(v[7:4]), 1'b0);
    push_byte(nibble_ascii(v[3:0]), 1'b0);
  endtask

  task automatic close_frame_bytes();
    logic [7:0] check;
    check = bcc_acc;
    push_hex(check);
    push_byte(ahfb_pkg::EndByte, 1'b1);
    frame_is_open = 1'b0;
    left_cnt = '0;
    bcc_acc = '0;
  endtask

  // Expand one accepted item into the frame bytes it produces
  task automatic build_frame_bytes(input ahfb_pkg::in_item_t it);
    logic [7:0] len_c;
    logic [7:0] low_part;
    logic [7:0] ctrl;
    if (it.op == ahfb_pkg::OpStart) begin
      len_c = (it.message_length > ahfb_pkg::MaxMessageLength) ?
              ahfb_pkg::MaxMessageLength : it.message_length;
      if (it.type_char_low > ahfb_pkg::AsciiNine) begin
        low_part = it.type_char_low - ahfb_pkg::AsciiUpperA + 8'd10;
      end else begin
        low_part = {4'h0, it.type_char_low[3:0]};
      end
      ctrl = {it.type_char_high[3:0], 4'h0} | low_part | ahfb_pkg::ControlTopBit;
      // A start drops any open frame without its trailer
      bcc_acc = '0;
      push_byte(ahfb_pkg::StartByte, 1'b0);
      for (int k = 0; k < 8; k++) begin
        push_byte(addr_first8[63-8*k -: 8], 1'b0);
      end
      push_byte(addr_last2[15:8], 1'b0);
      push_byte(addr_last2[7:0], 1'b0);
      push_hex(ctrl);
      push_hex(len_c);
      frame_is_open = 1'b1;
      left_cnt = len_c;
      if (left_cnt == 8'd0) begin
        close_frame_bytes();
      end
    end else if (frame_is_open) begin
      push_byte(it.message_byte, 1'b0);
      if (left_cnt != 8'd0) begin
        left_cnt = left_cnt - 8'd1;
      end
      if (left_cnt == 8'd0) begin
        close_frame_bytes();
      end
    end
  endtask

  function automatic ahfb_pkg::in_item_t mk_start(input logic [7:0] th,
                                                  input logic [7:0] tl,
                                                  input logic [7:0] len);
    ahfb_pkg::in_item_t it;
    it.op = ahfb_pkg::OpStart;
    it.type_char_high = th;
    it.type_char_low = tl;
    it.message_length = len;
    it.message_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Message byte; the unused fields carry noise
  function automatic ahfb_pkg::in_item_t mk_byte(input logic [7:0] mb);
    ahfb_pkg::in_item_t it;
    it.op = ahfb_pkg::OpByte;
    it.type_char_high = 8'($urandom_range(0, 255));
    it.type_char_low = 8'($urandom_range(0, 255));
    it.message_length = 8'($urandom_range(0, 255));
    it.message_byte = mb;
    return it;
  endfunction

  // Hex digit characters about half the time, otherwise any byte
  function automatic logic [7:0] rand_type_char();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 1) begin
      return nibble_ascii(n);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic apb_write(input logic [0:0] reg_idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == ahfb_pkg::RegAddrFirstEight) begin
      addr_first8 = val;
    end else begin
      addr_last2 = val[15:0];
    end
  endtask

  // Hold until every item is sent and every frame byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    while (items_to_send.size() != 0 || in_valid || frame_bytes_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    // Stray message byte with no frame open
    items_to_send.push_back(mk_byte(8'hA5));
    // Empty message closes at once
    items_to_send.push_back(mk_start(8'h30, 8'h30, 8'd0));
    items_to_send.push_back(mk_start(8'hFF, 8'hFF, 8'd2));
    items_to_send.push_back(mk_byte(8'h00));
    items_to_send.push_back(mk_byte(8'hFF));
    items_to_send.push_back(mk_start(8'h31, 8'h39, 8'd1));
    items_to_send.push_back(mk_byte(8'h7E));
    // Character just above the digits wraps in the low nibble
    items_to_send.push_back(mk_start(8'h00, 8'h3A, 8'd1));
    items_to_send.push_back(mk_byte(8'h55));
    items_to_send.push_back(mk_start(8'h33, 8'h41, 8'd0));
    // Oversized lengths are clamped; a new start drops the open frame
    items_to_send.push_back(mk_start(8'h46, 8'h46, 8'd255));
    items_to_send.push_back(mk_byte(8'h01));
    items_to_send.push_back(mk_byte(8'h80));
    items_to_send.push_back(mk_start(8'h34, 8'h61, 8'd238));
    items_to_send.push_back(mk_byte(8'h00));
    items_to_send.push_back(mk_start(8'h37, 8'h46, 8'd237));
    items_to_send.push_back(mk_start(8'h39, 8'h00, 8'd0));
    items_to_send.push_back(mk_byte(8'h00));
    items_to_send.push_back(mk_start(8'h41, 8'h43, 8'd3));
    items_to_send.push_back(mk_byte(8'hC3));
    items_to_send.push_back(mk_byte(8'h3C));
    items_to_send.push_back(mk_byte(8'h02));
  endtask

  // Mostly complete frames, plus truncated frames and stray bytes
  task automatic queue_random_frames(input int budget);
    int sent;
    int len;
    int body;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = (pick < 8) ? $urandom_range(9, 30) : $urandom_range(0, 6);
        items_to_send.push_back(mk_start(rand_type_char(), rand_type_char(), len[7:0]));
        for (int k = 0; k < len; k++) begin
          items_to_send.push_back(mk_byte(8'($urandom_range(0, 255))));
        end
        sent += len + 1;
        // Frame is closed here, so this byte is dropped by the block
        if ($urandom_range(0, 99) < 15) begin
          items_to_send.push_back(mk_byte(8'($urandom_range(0, 255))));
        end
      end else begin
        len = $urandom_range(1, 255);
        body = $urandom_range(0, (len > 6) ? 5 : len - 1);
        items_to_send.push_back(mk_start(rand_type_char(), rand_type_char(), len[7:0]));
        for (int k = 0; k < body; k++) begin
          items_to_send.push_back(mk_byte(8'($urandom_range(0, 255))));
        end
        sent += body + 1;
      end
    end
  endtask

  // Driver: present the next item, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        build_frame_bytes(in_item);
      end
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid <= 1'b1;
          in_item <= items_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Monitor: compare each output byte with the oldest pending one
  always @(posedge clk_i) begin : monitor
    ahfb_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h end %b",
                                  out_item.frame_byte, out_item.frame_end));
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_item.frame_byte !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte %h, want %h",
                                    out_item.frame_byte, want.frame_byte));
        end
        if (out_item.frame_end !== want.frame_end) begin
          report_mismatch($sformatf("frame_end %b, want %b",
                                    out_item.frame_end, want.frame_end));
        end
      end
    end
  end

  // Watchdog: give up after a long run with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames with every address bit set
    apb_write(ahfb_pkg::RegAddrFirstEight, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(ahfb_pkg::RegAddrLastTwo, 64'h0000_0000_0000_FFFF);
    @(negedge clk_i);
    queue_directed();
    wait_drained();

    // All-zero address, no idling on either side
    apb_write(ahfb_pkg::RegAddrFirstEight, 64'h0);
    apb_write(ahfb_pkg::RegAddrLastTwo, 64'h0);
    quiet = 1'b1;
    @(negedge clk_i);
    queue_random_frames(24);
    wait_drained();
    quiet = 1'b0;

    // Random address
    apb_write(ahfb_pkg::RegAddrFirstEight, {32'($urandom), 32'($urandom)});
    apb_write(ahfb_pkg::RegAddrLastTwo, 64'($urandom_range(0, 65535)));
    @(negedge clk_i);
    queue_random_frames(24);
    wait_drained();

    // Printable address
    apb_write(ahfb_pkg::RegAddrFirstEight, 64'h3031_3233_3435_3637);
    apb_write(ahfb_pkg::RegAddrLastTwo, 64'h0000_0000_0000_3839);
    @(negedge clk_i);
    queue_random_frames(24);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
